// File: rtl/polyline_length_macros.svh
// assertion macros shared by the polyline length checker
`ifndef POLYLINE_LENGTH_MACROS_SVH
`define POLYLINE_LENGTH_MACROS_SVH

// same-cycle implication, checked outside reset
`define PL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define PL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/pl_pkg.sv
// shared constants of the polyline length block
`timescale 1ns / 1ps

package pl_pkg;

    // default field widths
    localparam int PL_COORD_WIDTH  = 16;
    localparam int PL_LENGTH_WIDTH = 32;

endpackage

// File: rtl/polyline_length.sv
// Running Euclidean length of a polyline, bit-serial squares and square root.
// A first vertex of a polyline goes from IDLE straight to ACC; any other vertex passes the
// shift-add squaring pass (SQR) and the two-bits-per-cycle square root loop (ROOT), which
// share one sequencer, before ACC. ACC waits until the output register is free.
// One vertex is in flight at a time: the next is taken once the result is registered;
// reset: i_rst_n synchronous active low clears the control and state registers only.
`timescale 1ns / 1ps

module polyline_length
    import pl_pkg::*;
#(
    parameter int COORD_WIDTH  = PL_COORD_WIDTH,
    parameter int LENGTH_WIDTH = PL_LENGTH_WIDTH
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // vertex input: tdata = x_coord, y_coord (lowest first), tlast = last_point
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     i_s_tdata,
    input  logic                                   i_s_tlast,
    // result output: tdata = path_length, tuser = saturated, tlast = is_total
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    output logic [((LENGTH_WIDTH+7)/8)*8-1:0]      o_m_tdata,
    output logic                                   o_m_tuser,
    output logic                                   o_m_tlast
);

    localparam int CW    = COORD_WIDTH;
    localparam int LW    = LENGTH_WIDTH;
    localparam int OW    = ((LENGTH_WIDTH + 7) / 8) * 8;
    localparam int SQW   = 2 * CW + 1;           // sum of squares
    localparam int RW    = SQW + 1;              // radicand, even width
    localparam int RTW   = CW + 1;               // root
    localparam int REMW  = CW + 3;               // partial remainder
    localparam int SW    = ((LW > RTW) ? LW : RTW) + 1;
    localparam int CNTW  = $clog2(CW + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SQR  = 4'b0010,
        S_ROOT = 4'b0100,
        S_ACC  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CNTW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]       r_prev_x, n_prev_x;
    logic [CW-1:0]       r_prev_y, n_prev_y;
    logic [LW-1:0]       r_total, n_total;
    logic                r_have, n_have;
    logic                r_over, n_over;
    logic                r_dist_en, n_dist_en;
    logic                r_last, n_last;
    logic [CW-1:0]       r_dx, n_dx;
    logic [CW-1:0]       r_dy, n_dy;
    logic [CW-1:0]       r_mx, n_mx;
    logic [CW-1:0]       r_my, n_my;
    logic [SQW-1:0]      r_sq, n_sq;
    logic [RW-1:0]       r_rad, n_rad;
    logic [REMW-1:0]     r_rem, n_rem;
    logic [RTW-1:0]      r_root, n_root;
    logic                r_ovalid, n_ovalid;
    logic [LW-1:0]       r_olen, n_olen;
    logic                r_osat, n_osat;
    logic                r_olast, n_olast;

    logic [CW-1:0]       w_x, w_y;
    logic [CW:0]         w_diff_x, w_diff_y;
    logic [CW:0]         w_abs_x, w_abs_y;
    logic                w_in_xfer;
    logic                w_out_free;
    logic [SQW-1:0]      w_sq_next;
    logic [REMW-1:0]     w_rem_sh, w_trial;
    logic                w_ge;
    logic [SW-1:0]       w_sum;
    logic                w_sat;

    assign w_x        = i_s_tdata[CW-1:0];
    assign w_y        = i_s_tdata[2*CW-1:CW];
    assign o_s_tready = (r_state == S_IDLE);
    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_ovalid || i_m_tready;

    // absolute coordinate differences against the previous vertex
    always_comb begin
        w_diff_x = {w_x[CW-1], w_x} - {r_prev_x[CW-1], r_prev_x};
        w_diff_y = {w_y[CW-1], w_y} - {r_prev_y[CW-1], r_prev_y};
        w_abs_x  = w_diff_x[CW] ? (~w_diff_x + 1'b1) : w_diff_x;
        w_abs_y  = w_diff_y[CW] ? (~w_diff_y + 1'b1) : w_diff_y;
    end

    // shift-add squaring step, multiplier bits taken msb first
    assign w_sq_next = {r_sq[SQW-2:0], 1'b0}
                     + (r_mx[CW-1] ? {{(SQW-CW){1'b0}}, r_dx} : '0)
                     + (r_my[CW-1] ? {{(SQW-CW){1'b0}}, r_dy} : '0);

    // restoring square root step, two radicand bits per cycle
    assign w_rem_sh = {r_rem[REMW-3:0], r_rad[RW-1:RW-2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);

    // saturating accumulation
    always_comb begin
        w_sum = {{(SW-LW){1'b0}}, r_total};
        if (r_dist_en) begin
            w_sum = w_sum + {{(SW-RTW){1'b0}}, r_root};
        end
        w_sat = (w_sum >= {{(SW-LW){1'b0}}, {LW{1'b1}}});
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_prev_x  = r_prev_x;
        n_prev_y  = r_prev_y;
        n_total   = r_total;
        n_have    = r_have;
        n_over    = r_over;
        n_dist_en = r_dist_en;
        n_last    = r_last;
        n_dx      = r_dx;
        n_dy      = r_dy;
        n_mx      = r_mx;
        n_my      = r_my;
        n_sq      = r_sq;
        n_rad     = r_rad;
        n_rem     = r_rem;
        n_root    = r_root;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_olen    = r_olen;
        n_osat    = r_osat;
        n_olast   = r_olast;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_prev_x  = w_x;
                    n_prev_y  = w_y;
                    n_have    = 1'b1;
                    n_dist_en = r_have;
                    n_last    = i_s_tlast;
                    n_dx      = w_abs_x[CW-1:0];
                    n_dy      = w_abs_y[CW-1:0];
                    n_mx      = w_abs_x[CW-1:0];
                    n_my      = w_abs_y[CW-1:0];
                    n_sq      = '0;
                    n_cnt     = CNTW'(CW - 1);
                    n_state   = r_have ? S_SQR : S_ACC;
                end
            end
            S_SQR: begin
                n_sq = w_sq_next;
                n_mx = {r_mx[CW-2:0], 1'b0};
                n_my = {r_my[CW-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_rad   = {1'b0, w_sq_next};
                    n_rem   = '0;
                    n_root  = '0;
                    n_cnt   = CNTW'(CW);
                    n_state = S_ROOT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_ROOT: begin
                n_rad  = {r_rad[RW-3:0], 2'b00};
                n_rem  = w_ge ? (w_rem_sh - w_trial) : w_rem_sh;
                n_root = {r_root[RTW-2:0], w_ge};
                if (r_cnt == '0) begin
                    n_state = S_ACC;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_ACC: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_olen   = w_sat ? {LW{1'b1}} : w_sum[LW-1:0];
                    n_osat   = r_over || w_sat;
                    n_olast  = r_last;
                    n_total  = w_sat ? {LW{1'b1}} : w_sum[LW-1:0];
                    n_over   = r_over || w_sat;
                    // last vertex ends the polyline
                    if (r_last) begin
                        n_total  = '0;
                        n_over   = 1'b0;
                        n_have   = 1'b0;
                        n_prev_x = '0;
                        n_prev_y = '0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_total  <= '0;
            r_have   <= 1'b0;
            r_over   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_prev_x <= n_prev_x;
            r_prev_y <= n_prev_y;
            r_total  <= n_total;
            r_have   <= n_have;
            r_over   <= n_over;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_dist_en <= n_dist_en;
        r_last    <= n_last;
        r_dx      <= n_dx;
        r_dy      <= n_dy;
        r_mx      <= n_mx;
        r_my      <= n_my;
        r_sq      <= n_sq;
        r_rad     <= n_rad;
        r_rem     <= n_rem;
        r_root    <= n_root;
        r_olen    <= n_olen;
        r_osat    <= n_osat;
        r_olast   <= n_olast;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = OW'(r_olen);
    assign o_m_tuser  = r_osat;
    assign o_m_tlast  = r_olast;

endmodule

// File: rtl/pl_checker.sv
// port-level checks of the polyline length block and their binding
`timescale 1ns / 1ps
`include "polyline_length_macros.svh"

module pl_checker
    import pl_pkg::*;
#(
    parameter int COORD_WIDTH  = PL_COORD_WIDTH,
    parameter int LENGTH_WIDTH = PL_LENGTH_WIDTH
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                o_s_tready,
    // x_coord, y_coord from the lowest bit up
    input logic [((2*COORD_WIDTH+7)/8)*8-1:0]  i_s_tdata,
    input logic                                i_s_tlast,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    // path_length
    input logic [((LENGTH_WIDTH+7)/8)*8-1:0]   o_m_tdata,
    // saturated
    input logic                                o_m_tuser,
    input logic                                o_m_tlast
);

    logic w_out_stall;

    assign w_out_stall = o_m_tvalid && !i_m_tready;

    // a waiting result stays offered
    `PL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, o_m_tvalid)
    // a waiting result keeps its payload
    `PL_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, w_out_stall,
        $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
    // a saturated length reads all ones
    `PL_ASSERT_IMPL(a_sat_max, i_clk, i_rst_n, o_m_tvalid && o_m_tuser,
        o_m_tdata[LENGTH_WIDTH-1:0] == {LENGTH_WIDTH{1'b1}})
    // a taken vertex leaves the block busy in the cycle after it
    `PL_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

endmodule

bind polyline_length pl_checker #(
    .COORD_WIDTH  (COORD_WIDTH),
    .LENGTH_WIDTH (LENGTH_WIDTH)
) u_pl_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tlast  (i_s_tlast),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);
